/* hdl/dpf_pkg.sv */
// Package: shared widths, constants and verdict codes of the duplicate packet filter.
package dpf_pkg;
   localparam int CHANNELS_DEF = 64;
   localparam int DEPTH_DEF    = 16;
   localparam int CAP_W        = 5;
   localparam int TIME_W       = 64;
   localparam int RATE_W       = 16;
   localparam int COUNT_W      = 20;
   localparam int CHAN_W       = 6;
   localparam int VERDICT_W    = 4;

   typedef enum logic [VERDICT_W-1:0] {
      V_FIRST       = 4'd0,
      V_APPEND      = 4'd1,
      V_BACKFILL    = 4'd2,
      V_DUP         = 4'd3,
      V_OLD_STORED  = 4'd4,
      V_OLD_DROPPED = 4'd5,
      V_SLIP        = 4'd6,
      V_RATE_ERR    = 4'd7,
      V_INVALID     = 4'd8
   } verdict_type;

   // start-time tolerance by rate class; zero marks an unclassifiable rate
   function automatic logic [13:0] tol_of(input logic [RATE_W-1:0] r);
      logic [13:0] t;
      if (r < 16'd105)       t = 14'd15000;
      else if (r < 16'd255)  t = 14'd4500;
      else if (r < 16'd505)  t = 14'd2500;
      else if (r < 16'd1005) t = 14'd1500;
      else                   t = 14'd0;
      return t;
   endfunction
endpackage

/* hdl/duplicate_packet_filter.sv */
// Top level: duplicate packet filter with per-channel sorted header store.
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_channel req_start_time req_end_time
//          |           | req_sample_rate req_sample_count
//  rsp     | out       | rsp_valid rsp_ready rsp_allowed rsp_verdict
//  csr     | in        | csr_valid csr_ready csr_store_capacity
//
// A duplicate or rate error ends a packet's work at the match scan. One memory port walks
// the store for the match scan, the overlap scan, the trim copy and the shift of entries.
// Reset clears the fill levels of all channels before req_ready rises. req_ready is low
// while a packet is worked on and while its verdict waits in the output register.
module duplicate_packet_filter #(
   parameter int CHANNELS = dpf_pkg::CHANNELS_DEF,
   parameter int DEPTH    = dpf_pkg::DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dpf_pkg::CHAN_W-1:0]    req_channel,
   input  logic signed [dpf_pkg::TIME_W-1:0] req_start_time,
   input  logic signed [dpf_pkg::TIME_W-1:0] req_end_time,
   input  logic [dpf_pkg::RATE_W-1:0]    req_sample_rate,
   input  logic [dpf_pkg::COUNT_W-1:0]   req_sample_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_allowed,
   output logic [dpf_pkg::VERDICT_W-1:0] rsp_verdict,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [dpf_pkg::CAP_W-1:0]     csr_store_capacity
);
   import dpf_pkg::*;

   localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int POS_W = $clog2(DEPTH);
   localparam int N_W   = $clog2(DEPTH + 1);
   localparam int ADR_W = CH_W + POS_W;

   typedef struct packed {
      logic [TIME_W-1:0]  st;
      logic [TIME_W-1:0]  en;
      logic [RATE_W-1:0]  rate;
      logic [COUNT_W-1:0] cnt;
   } entry_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_FILL, S_DECIDE0, S_SCAN, S_CLASSIFY, S_OVL, S_TRIM,
      S_SHIFT_UP, S_INS, S_WRITE, S_DONE
   } state_type;

   // memories
   entry_type         store_mem [CHANNELS * (1 << POS_W)];
   logic [N_W-1:0]    fill_mem  [CHANNELS];
   entry_type         rd_ff;
   logic [N_W-1:0]    fill_rd_ff;

   state_type         state_ff;
   logic [CAP_W-1:0]  cap_ff;
   logic [CH_W-1:0]   ch_ff;
   entry_type         pkt_ff;
   logic [N_W-1:0]    n_ff;       // effective fill level
   logic [N_W-1:0]    keep_ff;    // entries kept after trim
   logic [N_W-1:0]    idx_ff;     // current read index
   logic [N_W-1:0]    pos_ff;     // write index
   logic [N_W-1:0]    drop_ff;
   logic              rvalid_ff;  // read data in rd_ff belongs to idx_ff issued last cycle
   logic [1:0]        phase_ff;
   logic [TIME_W-1:0] oldest_ff;
   logic              rsp_valid_ff;
   logic              allowed_ff;
   verdict_type       verdict_ff;
   logic              is_append_ff;

   // memory port controls
   logic              mem_we;
   logic [ADR_W-1:0]  mem_wa;
   entry_type         mem_wd;
   logic [ADR_W-1:0]  mem_ra;
   logic              fill_we;
   logic [CH_W-1:0]   fill_wa;
   logic [N_W-1:0]    fill_wd;

   logic [N_W-1:0]    cap_eff;
   logic [CH_W-1:0]   req_ch;
   logic              s_lt_pkt_rd;
   logic              s_lt_rdend_pkt;
   logic              e_lt_rdst;
   logic              s_ge_rd;
   logic              e_ge_rd;
   logic              e_le_rdend;
   logic [TIME_W:0]   diff;
   logic [TIME_W:0]   adiff;
   logic [13:0]       tol;

   always_comb begin
      if (cap_ff == '0)                     cap_eff = N_W'(1);
      else if (32'(cap_ff) > DEPTH)         cap_eff = N_W'(DEPTH);
      else                                  cap_eff = N_W'(cap_ff);
   end

   // channel folded onto the implemented channels by a constant table
   always_comb begin
      req_ch = '0;
      for (int i = 0; i < (1 << CHAN_W); i++)
         if (req_channel == CHAN_W'(i)) req_ch = CH_W'(i % CHANNELS);
   end

   // one shared signed compare set against the word read from the store
   assign s_lt_pkt_rd    = $signed(pkt_ff.st) < $signed(rd_ff.st);
   assign s_lt_rdend_pkt = $signed(rd_ff.en) < $signed(pkt_ff.st);
   assign e_lt_rdst      = $signed(pkt_ff.en) < $signed(rd_ff.st);
   assign s_ge_rd        = !s_lt_pkt_rd;
   assign e_ge_rd        = !e_lt_rdst;
   assign e_le_rdend     = !($signed(rd_ff.en) < $signed(pkt_ff.en));
   assign diff  = {rd_ff.st[TIME_W-1], rd_ff.st} - {pkt_ff.st[TIME_W-1], pkt_ff.st};
   assign adiff = diff[TIME_W] ? (~diff + 1'b1) : diff;
   assign tol   = tol_of(pkt_ff.rate);

   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_wa] <= mem_wd;
      rd_ff <= store_mem[mem_ra];
      if (fill_we) fill_mem[fill_wa] <= fill_wd;
      fill_rd_ff <= fill_mem[ch_ff];
   end

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_allowed = allowed_ff;
   assign rsp_verdict = verdict_ff;

   function automatic logic [ADR_W-1:0] adr(input logic [CH_W-1:0] c, input logic [N_W-1:0] p);
      return {c, p[POS_W-1:0]};
   endfunction

   // memory port drive
   always_comb begin
      mem_we  = 1'b0;
      mem_wa  = adr(ch_ff, pos_ff);
      mem_wd  = rd_ff;
      mem_ra  = adr(ch_ff, idx_ff);
      fill_we = 1'b0;
      fill_wa = ch_ff;
      fill_wd = '0;
      unique case (state_ff)
         S_CLEAR: begin
            fill_we = 1'b1;
            fill_wd = '0;
         end
         S_SCAN: begin
            // last check cycle: fetch the newest entry for the classification
            if (idx_ff == n_ff) mem_ra = adr(ch_ff, n_ff - 1'b1);
         end
         S_TRIM, S_SHIFT_UP: begin
            mem_we = rvalid_ff;
         end
         S_WRITE: begin
            mem_we  = 1'b1;
            mem_wd  = pkt_ff;
            fill_we = 1'b1;
            fill_wd = keep_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_ff       <= CAP_W'(16);
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         rvalid_ff    <= 1'b0;
      end else begin
         if (csr_valid) cap_ff <= csr_store_capacity;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_CLEAR: begin
               if (32'(ch_ff) == CHANNELS - 1) state_ff <= S_IDLE;
               ch_ff <= ch_ff + 1'b1;
            end
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  ch_ff  <= req_ch;
                  pkt_ff <= '{req_start_time, req_end_time, req_sample_rate,
                              req_sample_count};
                  state_ff <= S_FILL;
               end
            end
            S_FILL: state_ff <= S_DECIDE0;
            S_DECIDE0: begin
               n_ff <= (32'(fill_rd_ff) > DEPTH) ? N_W'(DEPTH) : fill_rd_ff;
               idx_ff <= '0;
               rvalid_ff <= 1'b0;
               if (pkt_ff.cnt == '0) begin
                  allowed_ff <= 1'b0; verdict_ff <= V_INVALID; state_ff <= S_DONE;
               end else if (fill_rd_ff == '0) begin
                  allowed_ff <= 1'b1; verdict_ff <= V_FIRST;
                  keep_ff <= '0; pos_ff <= '0; state_ff <= S_WRITE;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // idx_ff issued; rd_ff holds entry idx_ff-1 when rvalid_ff
               if (rvalid_ff) begin
                  if (idx_ff == N_W'(1)) oldest_ff <= rd_ff.st;
                  if (rd_ff.rate != pkt_ff.rate) begin
                     allowed_ff <= 1'b0; verdict_ff <= V_RATE_ERR; state_ff <= S_DONE;
                  end else if (rd_ff.cnt == pkt_ff.cnt && tol == '0) begin
                     allowed_ff <= 1'b0; verdict_ff <= V_RATE_ERR; state_ff <= S_DONE;
                  end else if (rd_ff.cnt == pkt_ff.cnt && adiff < (TIME_W+1)'(tol)) begin
                     allowed_ff <= 1'b0; verdict_ff <= V_DUP; state_ff <= S_DONE;
                  end else if (idx_ff == n_ff) begin
                     state_ff <= S_CLASSIFY;
                  end
               end
               if (idx_ff != n_ff) idx_ff <= idx_ff + 1'b1;
               rvalid_ff <= 1'b1;
            end
            S_CLASSIFY: begin
               // rd_ff holds the newest entry
               rvalid_ff <= 1'b0;
               if (s_lt_rdend_pkt) begin
                  allowed_ff <= 1'b1; verdict_ff <= V_APPEND;
                  is_append_ff <= 1'b1;
                  idx_ff <= '0;
                  keep_ff <= (n_ff > cap_eff - 1'b1) ? cap_eff - 1'b1 : n_ff;
                  drop_ff <= (n_ff > cap_eff - 1'b1) ? n_ff - (cap_eff - 1'b1) : '0;
                  phase_ff <= 2'd0;
                  state_ff <= S_TRIM;
               end else if ($signed(pkt_ff.en) < $signed(oldest_ff)) begin
                  if (n_ff < cap_eff) begin
                     allowed_ff <= 1'b0; verdict_ff <= V_OLD_STORED;
                     is_append_ff <= 1'b0;
                     keep_ff <= n_ff;
                     idx_ff <= n_ff - 1'b1; pos_ff <= n_ff;
                     state_ff <= S_SHIFT_UP;
                  end else begin
                     allowed_ff <= 1'b0; verdict_ff <= V_OLD_DROPPED; state_ff <= S_DONE;
                  end
               end else begin
                  idx_ff <= '0;
                  state_ff <= S_OVL;
               end
            end
            S_OVL: begin
               if (rvalid_ff) begin
                  if ((s_ge_rd && !s_lt_rdend_pkt) || (e_ge_rd && e_le_rdend)) begin
                     allowed_ff <= 1'b0; verdict_ff <= V_SLIP; state_ff <= S_DONE;
                  end else if (idx_ff == n_ff) begin
                     allowed_ff <= 1'b1; verdict_ff <= V_BACKFILL;
                     is_append_ff <= 1'b0;
                     keep_ff <= (n_ff > cap_eff - 1'b1) ? cap_eff - 1'b1 : n_ff;
                     drop_ff <= (n_ff > cap_eff - 1'b1) ? n_ff - (cap_eff - 1'b1) : '0;
                     idx_ff <= '0; rvalid_ff <= 1'b0;
                     state_ff <= S_TRIM;
                  end
               end
               if (state_ff == S_OVL && idx_ff != n_ff) idx_ff <= idx_ff + 1'b1;
               if (idx_ff != n_ff || !rvalid_ff) rvalid_ff <= 1'b1;
            end
            S_TRIM: begin
               // copy entry i+drop to i for i < keep
               if (drop_ff == '0 || keep_ff == '0) begin
                  rvalid_ff <= 1'b0;
                  if (is_append_ff || keep_ff == '0) begin
                     pos_ff <= keep_ff; state_ff <= S_WRITE;
                  end else begin
                     idx_ff <= keep_ff - 1'b1; pos_ff <= keep_ff;
                     state_ff <= S_INS;
                  end
               end else begin
                  if (!rvalid_ff) begin
                     idx_ff <= drop_ff; pos_ff <= '0; rvalid_ff <= 1'b1;
                     phase_ff <= 2'd0;
                  end else if (phase_ff == 2'd0) begin
                     // first read issued, data arrives next cycle
                     phase_ff <= 2'd1; rvalid_ff <= 1'b1;
                     idx_ff <= idx_ff + 1'b1;
                  end else begin
                     pos_ff <= pos_ff + 1'b1;
                     idx_ff <= idx_ff + 1'b1;
                     if (pos_ff + 1'b1 == keep_ff) drop_ff <= '0;
                  end
               end
            end
            S_INS: begin
               // shift entries up while packet start is below them
               if (!rvalid_ff) begin
                  rvalid_ff <= 1'b1;
               end else if (s_lt_pkt_rd) begin
                  state_ff <= S_SHIFT_UP;
               end else begin
                  rvalid_ff <= 1'b0; state_ff <= S_WRITE;
               end
            end
            S_SHIFT_UP: begin
               // rd_ff holds entry idx_ff once rvalid_ff; write it at pos_ff
               if (!rvalid_ff) begin
                  rvalid_ff <= 1'b1;
               end else begin
                  pos_ff <= pos_ff - 1'b1;
                  if (pos_ff == N_W'(1)) begin
                     rvalid_ff <= 1'b0; state_ff <= S_WRITE;
                  end else if (verdict_ff == V_OLD_STORED) begin
                     idx_ff <= idx_ff - 1'b1; rvalid_ff <= 1'b0;
                  end else begin
                     idx_ff <= idx_ff - 1'b1; rvalid_ff <= 1'b0;
                     state_ff <= S_INS;
                  end
               end
            end
            S_WRITE: state_ff <= S_DONE;
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // the store is never written outside the writing states
   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_TRIM || state_ff == S_SHIFT_UP || state_ff == S_WRITE))
      else $error("store written outside update");
   // a verdict always follows the finishing state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid)
      else $error("missing verdict");
   // allowed only with passing verdicts
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_allowed || rsp_verdict == V_FIRST || rsp_verdict == V_APPEND
                     || rsp_verdict == V_BACKFILL))
      else $error("allowed with a rejecting verdict");
endmodule

/* verif/tb_duplicate_packet_filter.sv */
// Testbench: random and directed packet headers for the duplicate packet filter, scoreboard checked.
`timescale 1ns / 100ps

module tb_duplicate_packet_filter;
   import dpf_pkg::*;

   localparam int NCH = CHANNELS_DEF;
   localparam int NDP = DEPTH_DEF;
   localparam int SETTLE = 3 * NDP + 30;

   typedef struct {
      logic signed [TIME_W-1:0] t0;
      logic signed [TIME_W-1:0] t1;
      logic [RATE_W-1:0]        rate;
      logic [COUNT_W-1:0]       cnt;
   } header_type;

   typedef struct {
      logic        allowed;
      verdict_type verdict;
   } result_type;

   class header_scoreboard;
      header_type held[NCH][NDP];
      int         fill[NCH];
      int         capacity;
      int         fails;
      result_type awaited[$];

      function new();
         capacity = 16;
         fails = 0;
         foreach (fill[i]) fill[i] = 0;
      endfunction

      function void drop_oldest(int ch, int keep);
         int drop;
         if (fill[ch] <= keep) return;
         drop = fill[ch] - keep;
         for (int i = 0; i < keep; i++) held[ch][i] = held[ch][i + drop];
         fill[ch] = keep;
      endfunction

      function void note_packet(logic [CHAN_W-1:0] chan, header_type h);
         int ch, cap, n, pos, tol;
         logic signed [TIME_W:0] d;
         logic done, slip;
         result_type res;
         ch = chan % NCH;
         cap = capacity;
         if (cap < 1) cap = 1;
         if (cap > NDP) cap = NDP;
         n = fill[ch];
         res.allowed = 0;
         done = 0;
         if (h.cnt == 0) begin
            res.verdict = V_INVALID;
         end else if (n == 0) begin
            held[ch][0] = h;
            fill[ch] = 1;
            res.verdict = V_FIRST;
            res.allowed = 1;
         end else begin
            for (int i = 0; i < n; i++) begin
               if (held[ch][i].rate != h.rate) begin
                  res.verdict = V_RATE_ERR;
                  done = 1;
                  break;
               end
               if (held[ch][i].cnt != h.cnt) continue;
               if (h.rate < 105) tol = 15000;
               else if (h.rate < 255) tol = 4500;
               else if (h.rate < 505) tol = 2500;
               else if (h.rate < 1005) tol = 1500;
               else begin
                  res.verdict = V_RATE_ERR;
                  done = 1;
                  break;
               end
               d = {h.t0[TIME_W-1], h.t0} - {held[ch][i].t0[TIME_W-1], held[ch][i].t0};
               if (d < 0) d = -d;
               if (d < tol) begin
                  res.verdict = V_DUP;
                  done = 1;
                  break;
               end
            end
            if (done) begin
            end else if (held[ch][n-1].t1 < h.t0) begin
               drop_oldest(ch, cap - 1);
               held[ch][fill[ch]] = h;
               fill[ch]++;
               res.verdict = V_APPEND;
               res.allowed = 1;
            end else if (h.t1 < held[ch][0].t0) begin
               if (n < cap) begin
                  for (int i = n; i > 0; i--) held[ch][i] = held[ch][i-1];
                  held[ch][0] = h;
                  fill[ch] = n + 1;
                  res.verdict = V_OLD_STORED;
               end else begin
                  res.verdict = V_OLD_DROPPED;
               end
            end else begin
               slip = 0;
               for (int i = 0; i < n; i++)
                  if ((h.t0 >= held[ch][i].t0 && h.t0 <= held[ch][i].t1) ||
                      (h.t1 >= held[ch][i].t0 && h.t1 <= held[ch][i].t1))
                     slip = 1;
               if (slip) begin
                  res.verdict = V_SLIP;
               end else begin
                  drop_oldest(ch, cap - 1);
                  n = fill[ch];
                  pos = n;
                  while (pos > 0 && h.t0 < held[ch][pos-1].t0) begin
                     held[ch][pos] = held[ch][pos-1];
                     pos--;
                  end
                  held[ch][pos] = h;
                  fill[ch] = n + 1;
                  res.verdict = V_BACKFILL;
                  res.allowed = 1;
               end
            end
         end
         awaited.insert(awaited.size(), res);
      endfunction

      function void check_result(logic allowed, logic [VERDICT_W-1:0] verdict);
         result_type x;
         if (awaited.size() == 0) begin
            $error("unexpected result: allowed %0d verdict %0d", allowed, verdict);
            fails++;
            return;
         end
         x = awaited.pop_front();
         if (allowed !== x.allowed) begin
            $error("allowed: expected %0d, actual %0d", x.allowed, allowed);
            fails++;
         end
         if (verdict !== x.verdict) begin
            $error("verdict: expected %0d, actual %0d", x.verdict, verdict);
            fails++;
         end
      endfunction
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   logic [CHAN_W-1:0]       req_channel;
   logic signed [TIME_W-1:0] req_start_time;
   logic signed [TIME_W-1:0] req_end_time;
   logic [RATE_W-1:0]       req_sample_rate;
   logic [COUNT_W-1:0]      req_sample_count;
   logic                    rsp_valid;
   logic                    rsp_ready;
   logic                    rsp_allowed;
   logic [VERDICT_W-1:0]    rsp_verdict;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CAP_W-1:0]        csr_store_capacity;

   header_scoreboard sb;
   bit calm;
   bit hold_request;

   // per-stream traffic state
   logic signed [TIME_W-1:0] cursor[8], oldest[8], last_t0[8], last_t1[8];
   logic signed [TIME_W-1:0] gap_t0[8];
   bit                       gap_open[8];
   logic [RATE_W-1:0]        stream_rate[8];
   logic [COUNT_W-1:0]       last_cnt[8];

   duplicate_packet_filter i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_channel(req_channel),
      .req_start_time(req_start_time), .req_end_time(req_end_time),
      .req_sample_rate(req_sample_rate), .req_sample_count(req_sample_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_allowed(rsp_allowed),
      .rsp_verdict(rsp_verdict), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_store_capacity(csr_store_capacity)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("FAIL");
      $finish;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_packet(logic [CHAN_W-1:0] ch, logic signed [TIME_W-1:0] t0,
                              logic signed [TIME_W-1:0] t1, logic [RATE_W-1:0] rate,
                              logic [COUNT_W-1:0] cnt);
      header_type h;
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid        <= 1;
      req_channel      <= ch;
      req_start_time   <= t0;
      req_end_time     <= t1;
      req_sample_rate  <= rate;
      req_sample_count <= cnt;
      do @(posedge clock); while (!req_ready);
      h.t0 = t0;
      h.t1 = t1;
      h.rate = rate;
      h.cnt = cnt;
      sb.note_packet(ch, h);
   endtask

   task automatic set_capacity(logic [CAP_W-1:0] v);
      req_valid <= 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid <= 1;
      csr_store_capacity <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.capacity = v;
   endtask

   task automatic random_packet();
      int k, pick;
      logic [CHAN_W-1:0] ch;
      logic signed [TIME_W-1:0] t0, t1;
      logic [COUNT_W-1:0] cnt;
      k = $urandom_range(7);
      ch = CHAN_W'(k * 9);
      pick = $urandom_range(99);
      cnt = COUNT_W'($urandom_range(1, 3));
      if (pick < 55 && !(pick >= 45 && gap_open[k])) begin
         if ($urandom_range(99) < 15) begin
            gap_t0[k] = cursor[k];
            gap_open[k] = 1;
            t0 = cursor[k] + 60000;
         end else begin
            t0 = cursor[k] + $urandom_range(1, 3000);
         end
         t1 = t0 + $urandom_range(100, 8000);
         cursor[k] = t1;
         last_t0[k] = t0;
         last_t1[k] = t1;
         last_cnt[k] = cnt;
         send_packet(ch, t0, t1, stream_rate[k], cnt);
      end else if (pick < 55) begin
         gap_open[k] = 0;
         t0 = gap_t0[k] + 20000 + $urandom_range(5000);
         send_packet(ch, t0, t0 + $urandom_range(100, 15000), stream_rate[k], cnt);
      end else if (pick < 67) begin
         t0 = last_t0[k] + $urandom_range(1000);
         send_packet(ch, t0, last_t1[k], stream_rate[k], last_cnt[k]);
      end else if (pick < 74) begin
         oldest[k] = oldest[k] - 50000;
         send_packet(ch, oldest[k], oldest[k] + 1000, stream_rate[k], cnt);
      end else if (pick < 82) begin
         send_packet(ch, last_t0[k] + 1, last_t1[k] + 5, stream_rate[k],
                     COUNT_W'(last_cnt[k] + 1000));
      end else if (pick < 88) begin
         send_packet(ch, cursor[k] + 10, cursor[k] + 20, RATE_W'(stream_rate[k] + 1), cnt);
      end else if (pick < 93) begin
         send_packet(ch, cursor[k] + 10, cursor[k] + 20, stream_rate[k], 0);
      end else begin
         send_packet(CHAN_W'($urandom), rand64(), rand64(), RATE_W'($urandom),
                     COUNT_W'($urandom));
      end
   endtask

   initial begin
      sb = new();
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_allowed, rsp_verdict);
      end
   end

   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready <= 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_left = 400;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_ready <= 0;
            hold_left--;
         end else begin
            rsp_ready <= calm || $urandom_range(99) >= 7;
         end
      end
   end

   initial begin
      logic [CAP_W-1:0] caps[8] = '{5'd16, 5'd1, 5'd0, 5'd5, 5'd31, 5'd2, 5'd16, 5'd8};
      logic [RATE_W-1:0] rates[8] = '{16'd50, 16'd150, 16'd300, 16'd700,
                                      16'd2000, 16'd104, 16'd504, 16'd1004};
      logic signed [TIME_W-1:0] tmin, tmax;
      tmin = {1'b1, 63'd0};
      tmax = {1'b0, {63{1'b1}}};
      calm = 0;
      hold_request = 0;
      reset <= 1;
      req_valid <= 0;
      req_channel <= 0;
      req_start_time <= 0;
      req_end_time <= 0;
      req_sample_rate <= 0;
      req_sample_count <= 0;
      csr_valid <= 0;
      csr_store_capacity <= 0;
      repeat (8) @(posedge clock);
      reset <= 0;
      for (int k = 0; k < 8; k++) begin
         cursor[k] = $signed(rand64()) >>> 2;
         oldest[k] = cursor[k];
         last_t0[k] = cursor[k];
         last_t1[k] = cursor[k];
         last_cnt[k] = 1;
         gap_open[k] = 0;
         stream_rate[k] = rates[k];
      end

      set_capacity(5'd16);
      // directed: extremes, every verdict
      send_packet(6'd63, tmin, tmax, 16'hFFFF, 20'hFFFFF);
      send_packet(6'd63, tmax, tmin, 16'hFFFF, 20'hFFFFF);
      send_packet(6'd62, 0, 100, 16'd50, 20'd0);
      send_packet(6'd62, 0, 100, 16'd50, 20'd4);
      send_packet(6'd62, 14999, 16000, 16'd50, 20'd4);
      send_packet(6'd62, 20000, 20500, 16'd50, 20'd4);
      send_packet(6'd62, 90000, 91000, 16'd50, 20'd5);
      send_packet(6'd62, 50000, 51000, 16'd50, 20'd6);
      send_packet(6'd62, 50500, 52000, 16'd50, 20'd7);
      send_packet(6'd62, -9000, -5000, 16'd50, 20'd8);
      send_packet(6'd62, 95000, 96000, 16'd51, 20'd9);
      send_packet(6'd61, 0, 10, 16'd1005, 20'd2);
      send_packet(6'd61, 100, 110, 16'd1005, 20'd3);
      send_packet(6'd61, 200000, 200010, 16'd1005, 20'd2);
      send_packet(6'd60, tmax - 10, tmax, 16'd255, 20'd1);
      send_packet(6'd60, tmin, tmin + 10, 16'd255, 20'd1);
      send_packet(6'd60, tmin + 20, tmin + 30, 16'd255, 20'd1);
      set_capacity(5'd1);
      send_packet(6'd60, tmin + 100, tmin + 110, 16'd255, 20'd2);
      send_packet(6'd60, tmin + 50, tmin + 60, 16'd255, 20'd3);
      send_packet(6'd62, 100000, 100100, 16'd50, 20'd1);

      for (int p = 0; p < 8; p++) begin
         set_capacity(caps[p]);
         calm = (p == 3);
         for (int i = 0; i < 160; i++) begin
            if (p == 1 && i == 40) hold_request = 1;
            random_packet();
         end
      end
      req_valid <= 0;
      calm = 0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (sb.fails == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
